// ----- rtl/mas_pkg.sv -----
// ----------------------------------------------------------------------------
// mas_pkg
// Shared constants for the moving average slicer.
// ----------------------------------------------------------------------------
`default_nettype none

package mas_pkg;

  localparam int SAMPLE_W                  = 16;
  localparam int MAG_W                     = 16;
  localparam int DEF_PULSE_SAMPLES         = 8;
  localparam int DEF_PULSES_IN_WINDOW      = 32;

endpackage

`default_nettype wire

// ----- rtl/mas_if.sv -----
// ----------------------------------------------------------------------------
// mas_sample_if / mas_decision_if
// Valid/ready channels for the sample input and the decision output.
// ----------------------------------------------------------------------------
`default_nettype none

interface mas_sample_if
  import mas_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mas_decision_if;
  logic valid;
  logic ready;
  logic decision;

  modport source (output valid, output decision, input ready);
  modport sink   (input valid, input decision, output ready);
endinterface

`default_nettype wire

// ----- rtl/mas_cell.sv -----
// ----------------------------------------------------------------------------
// mas_cell
// One magnitude cell of the window delay line; shifts on every accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module mas_cell
  import mas_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             shift,
  input  wire logic [MAG_W-1:0] mag_in,
  output logic      [MAG_W-1:0] mag_out
);

  logic [MAG_W-1:0] mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r <= '0;
    end else if (shift) begin
      mag_r <= mag_in;
    end
  end

  assign mag_out = mag_r;

endmodule

`default_nettype wire

// ----- rtl/mas_decide.sv -----
// ----------------------------------------------------------------------------
// mas_decide
// Scales the sample by the window length and compares it with the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mas_decide
  import mas_pkg::*;
#(
  parameter int WINDOW = DEF_PULSE_SAMPLES * DEF_PULSES_IN_WINDOW,
  parameter int SUM_W  = 15 + $clog2(WINDOW + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       s1_valid,
  output logic                            s1_ready,
  input  wire logic signed [SAMPLE_W-1:0] s1_sample,
  input  wire logic        [SUM_W-1:0]    s1_sum,
  mas_decision_if.source                  out_word
);

  localparam int PROD_W = SUM_W + 1;
  localparam logic signed [PROD_W-1:0] WIN_S = PROD_W'(WINDOW);

  logic                     v2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic        [SUM_W-1:0]  sum2_r;
  logic                     v3_r;
  logic                     decision_r;
  logic                     r2;
  logic                     r3;
  logic signed [PROD_W-1:0] samp_ext;

  assign r3       = !v3_r || out_word.ready;
  assign r2       = !v2_r || r3;
  assign s1_ready = r2;
  assign samp_ext = PROD_W'(s1_sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (r2) v2_r <= s1_valid;
      if (r3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && s1_valid) begin
      prod_r <= samp_ext * WIN_S;
      sum2_r <= s1_sum;
    end
    if (r3 && v2_r) begin
      decision_r <= (prod_r > $signed({1'b0, sum2_r}));
    end
  end

  assign out_word.valid    = v3_r;
  assign out_word.decision = decision_r;

endmodule

`default_nettype wire

// ----- rtl/moving_average_slicer_unit.sv -----
// ----------------------------------------------------------------------------
// moving_average_slicer_unit
// Hard slicer of a sample stream against its moving magnitude average.
// ----------------------------------------------------------------------------
// Each word on in_word carries one signed sample. The unit keeps the
// magnitudes of the last WINDOW samples (PULSE_SAMPLES times
// PULSES_IN_WINDOW) in a chain of cells that shifts once per accepted word,
// together with their exact sum. The oldest magnitude falls off the end of
// the chain and leaves the sum as the new one enters.
// out_word gives one decision word per sample: 1 when sample * WINDOW is
// above the updated sum, else 0.
// Throughput is one word per cycle while out_word is not stalled. Three
// register stages (sum update, constant multiply, compare) lie between the
// edge that accepts a sample and its decision on out_word.
// Each pipeline stage has its own ready, so while the receiver stalls the
// unit keeps accepting words until all three stages hold data.
// Synchronous reset clears the chain, the sum and all valid flags, so the
// first WINDOW samples are compared against a sum that still counts zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_slicer_unit
  import mas_pkg::*;
#(
  parameter int PULSE_SAMPLES    = DEF_PULSE_SAMPLES,
  parameter int PULSES_IN_WINDOW = DEF_PULSES_IN_WINDOW
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  mas_sample_if.sink     in_word,
  mas_decision_if.source out_word
);

  localparam int WINDOW = PULSE_SAMPLES * PULSES_IN_WINDOW;
  localparam int SUM_W  = 15 + $clog2(WINDOW + 1);

  logic                       accept;
  logic                       s1_ready;
  logic                       v1_r;
  logic signed [SAMPLE_W-1:0] samp1_r;
  logic        [SUM_W-1:0]    sum_r;
  logic        [SUM_W-1:0]    sum_nxt;
  logic        [SUM_W-1:0]    sum1_r;
  logic        [MAG_W-1:0]    mag;
  logic        [MAG_W-1:0]    chain [WINDOW+1];

  assign in_word.ready = !v1_r || s1_ready;
  assign accept        = in_word.valid && in_word.ready;

  // The most negative sample maps to 0x8000, which still fits unsigned.
  assign mag = in_word.sample[SAMPLE_W-1] ? MAG_W'(~in_word.sample + 1'b1)
                                          : MAG_W'(in_word.sample);

  assign chain[0] = mag;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    mas_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (accept),
      .mag_in  (chain[i]),
      .mag_out (chain[i+1])
    );
  end

  assign sum_nxt = sum_r - SUM_W'(chain[WINDOW]) + SUM_W'(mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      v1_r  <= 1'b0;
    end else begin
      if (accept) sum_r <= sum_nxt;
      if (in_word.ready) v1_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      samp1_r <= in_word.sample;
      sum1_r  <= sum_nxt;
    end
  end

  mas_decide #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (v1_r),
    .s1_ready  (s1_ready),
    .s1_sample (samp1_r),
    .s1_sum    (sum1_r),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ----- verif/moving_average_slicer_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// moving_average_slicer_unit_tb
// Self-checking bench for the moving magnitude average slicer.
// ----------------------------------------------------------------------------
// Samples go in on a valid/ready channel with random gaps, and decisions are
// drained with random back-pressure. A scoreboard keeps its own ring of
// magnitudes and their exact sum. For every accepted sample it queues the
// decision it expects, and it compares each decision word that comes out
// against the oldest one in the queue. The stimulus is a short list of edge
// values, then shaped random traffic: full-range noise, pulse-like bursts,
// values next to the current average and a long constant run that lands
// exactly on the average.
// ----------------------------------------------------------------------------
`default_nettype none

typedef logic signed [mas_pkg::SAMPLE_W-1:0] sample_t;

class slicer_scoreboard;
  localparam int WINDOW = mas_pkg::DEF_PULSE_SAMPLES * mas_pkg::DEF_PULSES_IN_WINDOW;

  bit [mas_pkg::MAG_W-1:0] mag_ring[WINDOW];
  int                      ring_pos;
  int                      mag_sum;
  bit                      decision_q[$];
  int                      error_count;

  function new();
    foreach (mag_ring[i]) mag_ring[i] = '0;
    ring_pos    = 0;
    mag_sum     = 0;
    error_count = 0;
  endfunction

  // The comparison uses the sum after the new magnitude has entered.
  function void note_sample(sample_t s);
    int s_val;
    int mag;
    s_val = s;
    mag = (s_val < 0) ? -s_val : s_val;
    mag_sum = mag_sum - int'(mag_ring[ring_pos]) + mag;
    mag_ring[ring_pos] = mag[mas_pkg::MAG_W-1:0];
    ring_pos = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
    decision_q.push_back(s_val * WINDOW > mag_sum);
  endfunction

  function void check_decision(logic d);
    bit want;
    if (decision_q.size() == 0) begin
      $error("decision: expected none, actual %0b", d);
      error_count++;
      return;
    end
    want = decision_q.pop_front();
    if (d !== want) begin
      $error("decision: expected %0b, actual %0b", want, d);
      error_count++;
    end
  endfunction

  function int pending();
    return decision_q.size();
  endfunction

  function int mean_magnitude();
    return mag_sum / WINDOW;
  endfunction
endclass

module moving_average_slicer_unit_tb;
  import mas_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  logic clk;
  logic rst_n;
  int   cycles = 0;
  int   decisions_seen;
  int   hold_left;
  bit   held_once;
  bit   steady;

  slicer_scoreboard board = new();

  mas_sample_if   in_if ();
  mas_decision_if out_if ();

  moving_average_slicer_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if.sink),
    .out_word (out_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic sample_t clamp_sample(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return sample_t'(v);
  endfunction

  function automatic sample_t pick_sample();
    int amp;
    int near;
    case ($urandom_range(9))
      0, 1, 2: return sample_t'($urandom_range(16'hffff));
      3, 4, 5: begin
        // Pulse-like: a strong level of either sign with some noise on it.
        amp = int'($urandom_range(30000, 8000));
        if ($urandom_range(1)) amp = -amp;
        return clamp_sample(amp + int'($urandom_range(1000)) - 500);
      end
      6, 7: return sample_t'(int'($urandom_range(64)) - 32);
      8: begin
        case ($urandom_range(3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: begin
        // Right around the current average, where the decision flips.
        near = board.mean_magnitude() + int'($urandom_range(2)) - 1;
        return clamp_sample(near);
      end
    endcase
  endfunction

  // Valid stays high after an accept, so whatever spends time next must
  // lower it first.
  task automatic send_sample(sample_t s);
    if (!steady) begin
      while ($urandom_range(99) < 37) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    board.note_sample(s);
  endtask

  task automatic drain_decisions();
    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sample_t opening_words[] = '{
      // Magnitude 255*128 then 128: the sum lands exactly on 128*WINDOW.
      -16'sd32640, 16'sd128,
      16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
      16'sh5555, 16'shaaaa, 16'sh7fff, 16'sh8000, 16'sh8000,
      16'sd256, -16'sd256, 16'sd2, -16'sd2, 16'sh7fff, 16'sh0000
    };
    sample_t level;

    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    steady        = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_words[i]) send_sample(opening_words[i]);

    repeat (250) send_sample(pick_sample());

    // Sender pauses here until every decision is back.
    drain_decisions();

    steady = 1'b1;
    repeat (150) send_sample(pick_sample());
    steady = 1'b0;

    // A constant positive run longer than the window ends up equal to the
    // average, which must slice low.
    level = sample_t'($urandom_range(32767, 1));
    repeat (260) send_sample(level);

    repeat (100) send_sample(pick_sample());

    drain_decisions();
    repeat (8) @(posedge clk);
    if (board.error_count == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    out_if.ready  <= 1'b0;
    decisions_seen = 0;
    hold_left      = 0;
    held_once      = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        board.check_decision(out_if.decision);
        decisions_seen++;
      end
      // One long hold-off while the sender keeps offering, so the pipeline
      // fills and in_word.ready drops.
      if (!held_once && decisions_seen >= 120) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (steady) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 37);
      end
    end
  end
endmodule

`default_nettype wire
